### rtl/u8u16_pkg.sv
package u8u16_pkg;

  // Byte classes of the UTF-8 decoder.
  localparam logic [7:0] ASCII_LO     = 8'h01;
  localparam logic [7:0] ASCII_HI     = 8'h7f;
  localparam logic [7:0] LEAD2_LO     = 8'hc2;
  localparam logic [7:0] LEAD2_HI     = 8'hdf;
  localparam logic [7:0] LEAD3_LO     = 8'he0;
  localparam logic [7:0] LEAD3_HI     = 8'hef;
  localparam logic [7:0] LEAD4_LO     = 8'hf0;
  localparam logic [7:0] LEAD4_HI     = 8'hf4;
  localparam logic [7:0] CONT_LO      = 8'h80;
  localparam logic [7:0] CONT_HI      = 8'hbf;

  // Scalar limits.
  localparam logic [20:0] MIN_2BYTE   = 21'h000080;
  localparam logic [20:0] MIN_3BYTE   = 21'h000800;
  localparam logic [20:0] MIN_4BYTE   = 21'h010000;
  localparam logic [20:0] SCALAR_MAX  = 21'h10ffff;
  localparam logic [20:0] SURR_LO     = 21'h00d800;
  localparam logic [20:0] SURR_HI     = 21'h00dfff;
  localparam logic [15:0] HI_SURR_BASE = 16'hd800;
  localparam logic [15:0] LO_SURR_BASE = 16'hdc00;

  // Sequence length classes (continuation bytes in the sequence).
  localparam logic [1:0] CLS_NONE     = 2'd0;
  localparam logic [1:0] CLS_TWO      = 2'd1;
  localparam logic [1:0] CLS_THREE    = 2'd2;
  localparam logic [1:0] CLS_FOUR     = 2'd3;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_INVALID   = 2'd1;
  localparam logic [1:0] ST_CAPACITY  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_CAPACITY       = 1'b0;
  localparam logic CFG_COUNT_ONLY     = 1'b1;

  localparam logic [15:0] CAPACITY_RESET = 16'hffff;

  // Queue between front and back.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // One queued job: up to two code units, or the final terminator.
  typedef struct packed {
    logic [15:0] unit0;
    logic [15:0] unit1;
    logic        two;
    logic        last;
    logic [1:0]  status;
    logic [15:0] count;
  } job_t;

endpackage

### rtl/utf8_to_utf16_transcoder.sv
// Channel   Handshake              Payload
// in_       in_valid / in_ready    in_data_byte, in_end_marker
// out_      out_valid / out_ready  out_code_unit, out_is_last, out_status, out_unit_count
// cfg_      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The decoder takes one byte beat per cycle while the four-entry job queue has room.
// A beat that completes a scalar goes into the job queue, then the output register.
// A surrogate pair is two code units; one result per cycle while out_ready is high.
// Reset (rst_n low, synchronous) clears the decoder, the queue and the output register.
// Output stalls back up through the queue into in_ready; cfg_ready is always high.
module utf8_to_utf16_transcoder
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_end_marker,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic        out_is_last,
  output logic [1:0]  out_status,
  output logic [15:0] out_unit_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  logic [15:0] capacity_r;
  logic        count_only_r;
  logic        accept;
  logic        push;
  job_t        push_job;
  logic        pop;
  logic        full;
  logic        empty;
  job_t        head;

  assign cfg_ready = 1'b1;
  assign in_ready  = !full;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r   <= CAPACITY_RESET;
      count_only_r <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CAPACITY:   capacity_r   <= cfg_data;
        CFG_COUNT_ONLY: count_only_r <= cfg_data[0];
        default:        capacity_r   <= capacity_r;
      endcase
    end
  end

  u8u16_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .end_marker (in_end_marker),
    .capacity   (capacity_r),
    .count_only (count_only_r),
    .push       (push),
    .push_job   (push_job)
  );

  u8u16_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .full     (full),
    .empty    (empty),
    .head     (head)
  );

  u8u16_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_code_unit  (out_code_unit),
    .out_is_last    (out_is_last),
    .out_status     (out_status),
    .out_unit_count (out_unit_count)
  );

endmodule

### rtl/u8u16_front.sv
module u8u16_front
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        end_marker,
  input  logic [15:0] capacity,
  input  logic        count_only,
  output logic        push,
  output job_t        push_job
);

  logic [20:0] acc_r, acc_nxt;
  logic [1:0]  rem_r, rem_nxt;
  logic [1:0]  cls_r, cls_nxt;
  logic [1:0]  err_r, err_nxt, err_dec;
  logic [15:0] cnt_r, cnt_nxt;

  logic        emit_req;
  logic [20:0] scalar;
  logic [20:0] acc_shift;
  logic [20:0] minimum;
  logic [1:0]  rem_dec;
  logic [1:0]  fin_status;

  logic        n2;
  logic [16:0] sum;
  logic        overflow;
  logic        emit0;
  logic        emit1;
  logic [19:0] offs;

  assign acc_shift = {acc_r[14:0], data_byte[5:0]};
  assign rem_dec   = rem_r - 2'd1;

  always_comb begin
    case (cls_r)
      CLS_TWO:   minimum = MIN_2BYTE;
      CLS_THREE: minimum = MIN_3BYTE;
      default:   minimum = MIN_4BYTE;
    endcase
  end

  // Decode one byte; a completed scalar raises emit_req.
  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    cls_nxt  = cls_r;
    err_dec  = err_r;
    emit_req = 1'b0;
    scalar   = 21'd0;
    if (accept) begin
      if (end_marker) begin
        acc_nxt = '0;
        rem_nxt = '0;
        cls_nxt = CLS_NONE;
        err_dec = ST_OK;
      end else if (err_r == ST_OK) begin
        if (rem_r == 2'd0) begin
          if (data_byte >= ASCII_LO && data_byte <= ASCII_HI) begin
            emit_req = 1'b1;
            scalar   = {13'd0, data_byte};
          end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
            acc_nxt = {16'd0, data_byte[4:0]};
            cls_nxt = CLS_TWO;
            rem_nxt = CLS_TWO;
          end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
            acc_nxt = {17'd0, data_byte[3:0]};
            cls_nxt = CLS_THREE;
            rem_nxt = CLS_THREE;
          end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
            acc_nxt = {18'd0, data_byte[2:0]};
            cls_nxt = CLS_FOUR;
            rem_nxt = CLS_FOUR;
          end else begin
            err_dec = ST_INVALID;
          end
        end else if (data_byte < CONT_LO || data_byte > CONT_HI) begin
          err_dec = ST_INVALID;
          rem_nxt = '0;
        end else begin
          acc_nxt = acc_shift;
          rem_nxt = rem_dec;
          if (rem_dec == 2'd0) begin
            acc_nxt = '0;
            cls_nxt = CLS_NONE;
            if (acc_shift < minimum || acc_shift > SCALAR_MAX ||
                (acc_shift >= SURR_LO && acc_shift <= SURR_HI)) begin
              err_dec = ST_INVALID;
            end else begin
              emit_req = 1'b1;
              scalar   = acc_shift;
            end
          end
        end
      end
    end
  end

  // Count the scalar and decide which of its units fit in the buffer.
  assign n2       = (scalar >= MIN_4BYTE);
  assign sum      = {1'b0, cnt_r} + (n2 ? 17'd2 : 17'd1);
  assign overflow = sum[16];
  assign emit0    = ({1'b0, cnt_r} + 17'd1) < {1'b0, capacity};
  assign emit1    = n2 && (({1'b0, cnt_r} + 17'd2) < {1'b0, capacity});
  assign offs     = scalar[19:0] - MIN_4BYTE[19:0];

  always_comb begin
    fin_status = err_r;
    if (fin_status == ST_OK && rem_r != 2'd0) begin
      fin_status = ST_INVALID;
    end
    if (fin_status == ST_OK && !count_only && cnt_r >= capacity) begin
      fin_status = ST_CAPACITY;
    end
  end

  always_comb begin
    err_nxt  = err_dec;
    cnt_nxt  = cnt_r;
    push     = 1'b0;
    push_job = '0;
    if (accept && end_marker) begin
      cnt_nxt         = '0;
      push            = 1'b1;
      push_job.last   = 1'b1;
      push_job.status = fin_status;
      push_job.count  = (fin_status == ST_INVALID) ? 16'd0 : cnt_r;
    end else if (emit_req) begin
      if (overflow) begin
        err_nxt = ST_CAPACITY;
        cnt_nxt = 16'hffff;
      end else begin
        cnt_nxt = sum[15:0];
        push    = !count_only && emit0;
        if (n2) begin
          push_job.unit0 = HI_SURR_BASE | {6'd0, offs[19:10]};
          push_job.unit1 = LO_SURR_BASE | {6'd0, offs[9:0]};
          push_job.two   = emit1;
        end else begin
          push_job.unit0 = scalar[15:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      rem_r <= '0;
      cls_r <= CLS_NONE;
      err_r <= ST_OK;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      rem_r <= rem_nxt;
      cls_r <= cls_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### rtl/u8u16_queue.sv
module u8u16_queue
  import u8u16_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  job_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QPTR_W:0]   fill_r, fill_nxt;

  assign full  = (fill_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty = (fill_r == '0);
  assign head  = mem[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

### rtl/u8u16_back.sv
module u8u16_back
  import u8u16_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        empty,
  input  job_t        head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_code_unit,
  output logic        out_is_last,
  output logic [1:0]  out_status,
  output logic [15:0] out_unit_count
);

  logic        valid_r, valid_nxt;
  logic        phase_r, phase_nxt;
  logic        load;
  logic [15:0] unit_r;
  logic        last_r;
  logic [1:0]  status_r;
  logic [15:0] count_r;

  // The output register takes a new beat whenever the queue holds a job and the register is empty or being drained.
  assign load = !empty && (!valid_r || out_ready);

  always_comb begin
    pop       = 1'b0;
    phase_nxt = phase_r;
    valid_nxt = valid_r && !out_ready;
    if (load) begin
      valid_nxt = 1'b1;
      if (!phase_r && head.two) begin
        phase_nxt = 1'b1;
      end else begin
        phase_nxt = 1'b0;
        pop       = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (phase_r) begin
        unit_r   <= head.unit1;
        last_r   <= 1'b0;
        status_r <= ST_OK;
        count_r  <= '0;
      end else begin
        unit_r   <= head.unit0;
        last_r   <= head.last;
        status_r <= head.status;
        count_r  <= head.count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_code_unit  = unit_r;
  assign out_is_last    = last_r;
  assign out_status     = status_r;
  assign out_unit_count = count_r;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import u8u16_pkg::*;

  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 16;
  localparam int N_DIRECTED   = 30;

  // How a directed row is checked.
  localparam logic [1:0] EXP_PREDICT = 2'd0;
  localparam logic [1:0] EXP_NONE    = 2'd1;
  localparam logic [1:0] EXP_ONE     = 2'd2;

  typedef struct packed {
    logic [15:0] unit;
    logic        last;
    logic [1:0]  status;
    logic [15:0] count;
  } utf16_result_t;

  typedef struct packed {
    logic [7:0]    data;
    logic          endm;
    logic [1:0]    check;
    utf16_result_t typed;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_end_marker = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_code_unit;
  logic        out_is_last;
  logic [1:0]  out_status;
  logic [15:0] out_unit_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = CFG_CAPACITY;
  logic [15:0] cfg_data = 16'h0000;

  utf16_result_t pending_utf16[$];
  utf16_result_t beat_units[$];
  stim_row_t     directed_rows [N_DIRECTED];

  // Decoder state and register copies.
  logic [20:0] acc_scalar = '0;
  logic [1:0]  conts_left = 2'd0;
  logic [1:0]  seq_class = CLS_NONE;
  logic [1:0]  fault = ST_OK;
  int          units_needed = 0;
  int          capacity = int'(CAPACITY_RESET);
  logic        count_only_mode = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int accepted_bytes = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count;

  utf8_to_utf16_transcoder dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_end_marker (in_end_marker),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_code_unit (out_code_unit),
    .out_is_last   (out_is_last),
    .out_status    (out_status),
    .out_unit_count(out_unit_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #1 clk = ~clk;

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic void count_and_emit(input logic [20:0] s);
    int            n;
    int            base;
    int            i;
    logic [20:0]   v;
    logic [15:0]   u0;
    logic [15:0]   u1;
    utf16_result_t r;
    n = (s >= MIN_4BYTE) ? 2 : 1;
    base = units_needed;
    u1 = 16'h0000;
    if (base + n > 65535) begin
      fault = ST_CAPACITY;
      units_needed = 65535;
    end else begin
      units_needed = base + n;
      v = s - MIN_4BYTE;
      if (n == 2) begin
        u0 = HI_SURR_BASE | {6'd0, v[19:10]};
        u1 = LO_SURR_BASE | {6'd0, v[9:0]};
      end else begin
        u0 = s[15:0];
      end
      if (!count_only_mode) begin
        for (i = 0; i < n; i++) begin
          // Units past the buffer are counted but dropped.
          if (base + i + 1 < capacity) begin
            r = '0;
            r.unit = (i == 0) ? u0 : u1;
            beat_units.push_back(r);
          end
        end
      end
    end
  endfunction

  function automatic void decode_beat(input logic [7:0] b, input logic e);
    logic [20:0]   s;
    logic [20:0]   floor_val;
    utf16_result_t r;
    if (e) begin
      r = '0;
      r.last = 1'b1;
      r.status = fault;
      if (r.status == ST_OK && conts_left != 2'd0) r.status = ST_INVALID;
      if (r.status == ST_OK && !count_only_mode && units_needed >= capacity)
        r.status = ST_CAPACITY;
      r.count = (r.status == ST_INVALID) ? 16'h0000 : units_needed[15:0];
      beat_units.push_back(r);
      acc_scalar = '0;
      conts_left = 2'd0;
      seq_class = CLS_NONE;
      fault = ST_OK;
      units_needed = 0;
    end else if (fault == ST_OK) begin
      if (conts_left == 2'd0) begin
        if (b >= ASCII_LO && b <= ASCII_HI) begin
          count_and_emit({13'd0, b});
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          acc_scalar = {16'd0, b[4:0]};
          seq_class = CLS_TWO;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          acc_scalar = {17'd0, b[3:0]};
          seq_class = CLS_THREE;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          acc_scalar = {18'd0, b[2:0]};
          seq_class = CLS_FOUR;
        end else begin
          fault = ST_INVALID;
        end
        // The class is still none unless a lead byte was just taken.
        conts_left = seq_class;
      end else if (b < CONT_LO || b > CONT_HI) begin
        fault = ST_INVALID;
        conts_left = 2'd0;
      end else begin
        acc_scalar = {acc_scalar[14:0], b[5:0]};
        conts_left = conts_left - 2'd1;
        if (conts_left == 2'd0) begin
          s = acc_scalar;
          floor_val = (seq_class == CLS_TWO) ? MIN_2BYTE :
                      (seq_class == CLS_THREE) ? MIN_3BYTE : MIN_4BYTE;
          acc_scalar = '0;
          seq_class = CLS_NONE;
          if (s < floor_val || s > SCALAR_MAX || (s >= SURR_LO && s <= SURR_HI))
            fault = ST_INVALID;
          else
            count_and_emit(s);
        end
      end
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < 100) $display("MISMATCH: %s", msg);
    mismatches++;
  endtask

  always @(posedge clk) begin : check_results
    utf16_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_utf16.size() == 0) begin
        report_mismatch($sformatf("result %0d (unit %h last %b) arrived with nothing expected",
                                  results_seen, out_code_unit, out_is_last));
      end else begin
        want = pending_utf16.pop_front();
        if (out_code_unit !== want.unit)
          report_mismatch($sformatf("result %0d: code_unit %h, expected %h",
                                    results_seen, out_code_unit, want.unit));
        if (out_is_last !== want.last)
          report_mismatch($sformatf("result %0d: is_last %b, expected %b",
                                    results_seen, out_is_last, want.last));
        if (out_status !== want.status)
          report_mismatch($sformatf("result %0d: status %0d, expected %0d",
                                    results_seen, out_status, want.status));
        if (out_unit_count !== want.count)
          report_mismatch($sformatf("result %0d: unit_count %0d, expected %0d",
                                    results_seen, out_unit_count, want.count));
      end
      results_seen++;
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  // Valid is left high so that a following beat does not drop it.
  task automatic send_beat(input logic [7:0] b, input logic e, input logic [1:0] check,
                           input utf16_result_t typed);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_data_byte  <= b;
    in_end_marker <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    accepted_bytes++;
    beat_units.delete();
    decode_beat(b, e);
    if (check == EXP_PREDICT) begin
      foreach (beat_units[k]) pending_utf16.push_back(beat_units[k]);
    end else if (check == EXP_ONE) begin
      pending_utf16.push_back(typed);
    end
    @(negedge clk);
  endtask

  task automatic push_byte(input logic [7:0] b);
    send_beat(b, 1'b0, EXP_PREDICT, '0);
  endtask

  task automatic end_string();
    send_beat(8'($urandom_range(0, 255)), 1'b1, EXP_PREDICT, '0);
  endtask

  // Sends the lead byte of s in an encoding with ncont continuation bytes,
  // then the first nsent of those continuation bytes.
  task automatic send_scalar(input logic [20:0] s, input int ncont, input int nsent);
    int          k;
    logic [20:0] t;
    case (ncont)
      0:       push_byte(s[7:0]);
      1:       push_byte({3'b110, s[10:6]});
      2:       push_byte({4'b1110, s[15:12]});
      default: push_byte({5'b11110, s[20:18]});
    endcase
    for (k = 0; k < nsent; k++) begin
      t = s >> (6 * (ncont - 1 - k));
      push_byte({2'b10, t[5:0]});
    end
  endtask

  task automatic send_random_string();
    int          n_scalars;
    int          k;
    int          pick;
    int          ncont;
    logic [20:0] s;
    logic [7:0]  b;
    n_scalars = $urandom_range(0, 8);
    for (k = 0; k < n_scalars; k++) begin
      pick = $urandom_range(0, 99);
      ncont = $urandom_range(1, 3);
      case (ncont)
        1:       s = 21'($urandom_range(32'h80, 32'h7ff));
        2:       s = 21'($urandom_range(32'h800, 32'hffff));
        default: s = 21'($urandom_range(32'h10000, 32'h10ffff));
      endcase
      if (s >= SURR_LO && s <= SURR_HI) s[14] = 1'b0;
      if (pick < 20) begin
        push_byte(8'($urandom_range(1, 127)));
      end else if (pick < 72) begin
        send_scalar(s, ncont, ncont);
      end else if (pick < 77) begin
        push_byte(8'($urandom_range(0, 255)));
      end else if (pick < 83) begin
        // Overlong: a scalar below the floor of its encoding length.
        s = 21'((ncont == 1) ? $urandom_range(0, 32'h7f) :
                (ncont == 2) ? $urandom_range(0, 32'h7ff) : $urandom_range(0, 32'hffff));
        send_scalar(s, ncont, ncont);
      end else if (pick < 87) begin
        send_scalar(21'($urandom_range(SURR_LO, SURR_HI)), 2, 2);
      end else if (pick < 91) begin
        send_scalar(21'($urandom_range(32'h110000, 32'h1fffff)), 3, 3);
      end else if (pick < 96) begin
        send_scalar(s, ncont, int'($urandom_range(0, ncont - 1)));
        b = 8'($urandom_range(0, 255));
        if (b >= CONT_LO && b <= CONT_HI) b = b ^ 8'h40;
        push_byte(b);
      end else begin
        // Truncated sequence right before the end marker.
        send_scalar(s, ncont, int'($urandom_range(0, ncont - 1)));
        k = n_scalars;
      end
    end
    end_string();
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_utf16.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_CAPACITY) capacity = int'(val);
    else count_only_mode = val[0];
    @(negedge clk);
  endtask

  task automatic set_config(input logic [15:0] cap, input logic co);
    settle();
    write_reg(CFG_CAPACITY, cap);
    write_reg(CFG_COUNT_ONLY, {15'd0, co});
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input logic [15:0] cap, input logic co, input int n_items);
    int stop_at;
    set_config(cap, co);
    stop_at = accepted_bytes + n_items;
    while (accepted_bytes < stop_at) send_random_string();
  endtask

  initial begin
    for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clk);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int i;
    directed_rows = '{
      '{8'h00, 1'b1, EXP_ONE,     '{16'h0000, 1'b1, ST_OK, 16'd0}},  // empty string
      '{8'h01, 1'b0, EXP_ONE,     '{16'h0001, 1'b0, ST_OK, 16'd0}},
      '{8'h7f, 1'b0, EXP_ONE,     '{16'h007f, 1'b0, ST_OK, 16'd0}},
      '{8'hc2, 1'b0, EXP_NONE,    '0},
      '{8'h80, 1'b0, EXP_PREDICT, '0},
      '{8'he0, 1'b0, EXP_NONE,    '0},
      '{8'ha0, 1'b0, EXP_NONE,    '0},
      '{8'h80, 1'b0, EXP_PREDICT, '0},
      '{8'hef, 1'b0, EXP_NONE,    '0},
      '{8'hbf, 1'b0, EXP_NONE,    '0},
      '{8'hbf, 1'b0, EXP_PREDICT, '0},
      '{8'hf0, 1'b0, EXP_NONE,    '0},  // first scalar that needs a pair
      '{8'h90, 1'b0, EXP_NONE,    '0},
      '{8'h80, 1'b0, EXP_NONE,    '0},
      '{8'h80, 1'b0, EXP_PREDICT, '0},
      '{8'hf4, 1'b0, EXP_NONE,    '0},  // highest legal scalar
      '{8'h8f, 1'b0, EXP_NONE,    '0},
      '{8'hbf, 1'b0, EXP_NONE,    '0},
      '{8'hbf, 1'b0, EXP_PREDICT, '0},
      '{8'hff, 1'b1, EXP_PREDICT, '0},
      '{8'h00, 1'b0, EXP_NONE,    '0},  // NUL is rejected
      '{8'h41, 1'b0, EXP_NONE,    '0},  // ignored once the error is set
      '{8'h00, 1'b1, EXP_ONE,     '{16'h0000, 1'b1, ST_INVALID, 16'd0}},
      '{8'hed, 1'b0, EXP_NONE,    '0},  // encoded surrogate
      '{8'ha0, 1'b0, EXP_NONE,    '0},
      '{8'h80, 1'b0, EXP_NONE,    '0},
      '{8'h00, 1'b1, EXP_ONE,     '{16'h0000, 1'b1, ST_INVALID, 16'd0}},
      '{8'he2, 1'b0, EXP_NONE,    '0},  // cut short by the end marker
      '{8'h82, 1'b0, EXP_NONE,    '0},
      '{8'h00, 1'b1, EXP_ONE,     '{16'h0000, 1'b1, ST_INVALID, 16'd0}}
    };

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 23;
    recv_idle_pct = 48;
    for (i = 0; i < N_DIRECTED; i++)
      send_beat(directed_rows[i].data, directed_rows[i].endm, directed_rows[i].check,
                directed_rows[i].typed);
    run_phase(16'hffff, 1'b0, 100);
    run_phase(16'h0000, 1'b0, 50);
    run_phase(16'h0001, 1'b0, 50);

    send_idle_pct = 48;
    recv_idle_pct = 23;
    run_phase(16'h0002, 1'b0, 60);
    run_phase(16'h0003, 1'b0, 60);
    run_phase(16'($urandom_range(4, 16)), 1'b0, 60);
    run_phase(16'($urandom_range(0, 65535)), 1'b1, 60);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(16'($urandom_range(5, 40)), 1'b0, 60);
    run_phase(16'h0000, 1'b1, 50);

    settle();
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### filelist.f
rtl/u8u16_pkg.sv
rtl/u8u16_front.sv
rtl/u8u16_queue.sv
rtl/u8u16_back.sv
rtl/utf8_to_utf16_transcoder.sv
tb/sv/testbench.sv
